// ----- hw/rtl/lpfp_pkg.sv -----
// Package for the range-finder point filter and projection core.
// Holds the transfer payload types, register indexes and CORDIC constants.
// No dependencies.
`default_nettype none

package lpfp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_QUALITY  = 3'd0,
    CFG_MAX_DISTANCE = 3'd1,
    CFG_SCALE        = 3'd2,
    CFG_CENTER_X     = 3'd3,
    CFG_CENTER_Y     = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Input measurement
  typedef struct packed {
    logic [15:0] distance_q2;
    logic [15:0] angle_phase;
    logic [7:0]  quality_raw;
  } point_in_t;

  // Projected result
  typedef struct packed {
    logic               keep;
    logic signed [11:0] screen_x;
    logic signed [11:0] screen_y;
    logic [7:0]         intensity;
  } point_out_t;

  // Data that rides along the CORDIC stages
  typedef struct packed {
    logic        keep;
    logic        flip;
    logic [31:0] range_q18;
    logic [7:0]  intensity;
  } side_t;

  // CORDIC constants: gain in Q30, angles in units of 2^32 per turn
  localparam int unsigned        AtanEntries = 24;
  localparam logic signed [31:0] GainQ30     = 32'sd652032874;
  localparam logic signed [31:0] AtanTurn32 [AtanEntries] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

`default_nettype wire

// ----- hw/rtl/lpfp_front.sv -----
// Front stage: quality, filter decision, intensity, range product and angle fold.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_front import lpfp_pkg::*; #(
  parameter int unsigned QUALITY_SHIFT = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire point_in_t          data_i,
  input  wire logic [5:0]         min_quality_i,
  input  wire logic [13:0]        max_distance_i,
  input  wire logic [15:0]        scale_i,
  output logic                    valid_o,
  output logic signed [31:0]      z_o,
  output side_t                   side_o
);

  logic [7:0]         quality;
  logic [14:0]        q_x127;
  logic [15:0]        q_x127_p1;
  logic [15:0]        div_sum;
  logic [7:0]         div255;
  logic [8:0]         inten_sum;
  logic [7:0]         inten;
  logic               keep;
  logic [31:0]        range_q18;
  logic signed [16:0] ang_s;
  logic signed [16:0] ang_fold;
  logic               flip;

  logic               valid_q;
  logic signed [31:0] z_q;
  side_t              side_q;

  // Quality, filters
  assign quality = data_i.quality_raw >> QUALITY_SHIFT;
  assign keep    = (data_i.distance_q2 != 16'd0)
                && (quality >= {2'b00, min_quality_i})
                && (data_i.distance_q2 <= {max_distance_i, 2'b00});

  // Intensity: 128 + q*127/255, the divide done as (x+1 + (x+1)>>8) >> 8
  assign q_x127    = {quality, 7'b0} - {7'b0, quality};
  assign q_x127_p1 = {1'b0, q_x127} + 16'd1;
  assign div_sum   = q_x127_p1 + (q_x127_p1 >> 8);
  assign div255    = div_sum[15:8];
  assign inten_sum = 9'd128 + {1'b0, div255};
  assign inten     = inten_sum[8] ? 8'd255 : inten_sum[7:0];

  // Scaled range in Q18 pixels
  assign range_q18 = data_i.distance_q2 * scale_i;

  // Fold bearing into [-90, +90] degrees
  assign ang_s = {data_i.angle_phase[15], data_i.angle_phase};
  always_comb begin
    ang_fold = ang_s;
    flip     = 1'b0;
    if (ang_s > 17'sd16384) begin
      ang_fold = ang_s - 17'sd32768;
      flip     = 1'b1;
    end else if (ang_s < -17'sd16384) begin
      ang_fold = ang_s + 17'sd32768;
      flip     = 1'b1;
    end
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q              <= {ang_fold[15:0], 16'b0};
      side_q.keep      <= keep;
      side_q.flip      <= flip;
      side_q.range_q18 <= range_q18;
      side_q.intensity <= inten;
    end
  end

  assign valid_o = valid_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lpfp_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_cordic import lpfp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] z_i,
  input  wire side_t              side_i,
  output logic                    valid_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o,
  output side_t                   side_o
);

  logic [CORDIC_STAGES-1:0] valid_q;
  logic signed [31:0]       x_q    [CORDIC_STAGES];
  logic signed [31:0]       y_q    [CORDIC_STAGES];
  logic signed [31:0]       z_q    [CORDIC_STAGES-1];
  side_t                    side_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic               v_in;
    side_t              s_in;
    logic signed [31:0] x_nxt;
    logic signed [31:0] y_nxt;

    // Stage inputs
    if (i == 0) begin : g_first
      assign x_in = GainQ30;
      assign y_in = 32'sd0;
      assign z_in = z_i;
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = valid_q[i-1];
      assign s_in = side_q[i-1];
    end

    // Micro-rotation, direction from the residual angle sign
    always_comb begin
      if (!z_in[31]) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_nxt;
        y_q[i]    <= y_nxt;
        side_q[i] <= s_in;
      end
    end

    // Residual angle is not needed after the last stage
    if (i != CORDIC_STAGES - 1) begin : g_zreg
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= z_in[31] ? (z_in + AtanTurn32[i]) : (z_in - AtanTurn32[i]);
        end
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STAGES-1];
  assign cos_o   = x_q[CORDIC_STAGES-1];
  assign sin_o   = y_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/lpfp_project.sv -----
// Projection back end: Q1.15 rounding, range multiply, offset and saturation.
// Three register stages; the last one is the output register. Depends on lpfp_pkg.
`default_nettype none

module lpfp_project import lpfp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] cos_i,
  input  wire logic signed [31:0] sin_i,
  input  wire side_t              side_i,
  input  wire logic [10:0]        center_x_i,
  input  wire logic [10:0]        center_y_i,
  output logic                    valid_o,
  output point_out_t              data_o
);

  // Round Q30 to Q1.15, clamp to +-32767
  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] sum;
    logic signed [17:0] rnd;
    sum = {v[31], v} + 33'sd16384;
    rnd = sum[32:15];
    if (rnd > 18'sd32767) begin
      return 16'sd32767;
    end else if (rnd < -18'sd32767) begin
      return -16'sd32767;
    end
    return rnd[15:0];
  endfunction

  // Clamp to the 12-bit screen range
  function automatic logic signed [11:0] sat12(input logic signed [15:0] v);
    if (v > 16'sd2047) begin
      return 12'sd2047;
    end else if (v < -16'sd2048) begin
      return -12'sd2048;
    end
    return v[11:0];
  endfunction

  // Stage 1: rounded, unfolded sine and cosine
  logic signed [15:0] sin_r;
  logic signed [15:0] cos_r;
  logic               v1_q;
  logic signed [15:0] sin1_q;
  logic signed [15:0] cos1_q;
  side_t              side1_q;

  assign sin_r = side_i.flip ? -to_q15(sin_i) : to_q15(sin_i);
  assign cos_r = side_i.flip ? -to_q15(cos_i) : to_q15(cos_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin1_q  <= sin_r;
      cos1_q  <= cos_r;
      side1_q <= side_i;
    end
  end

  // Stage 2: range times magnitude
  logic signed [15:0] sin_abs;
  logic signed [15:0] cos_abs;
  logic               v2_q;
  logic [46:0]        px2_q;
  logic [46:0]        py2_q;
  logic               sx_neg2_q;
  logic               sy_neg2_q;
  logic               keep2_q;
  logic [7:0]         inten2_q;

  assign sin_abs = sin1_q[15] ? -sin1_q : sin1_q;
  assign cos_abs = cos1_q[15] ? -cos1_q : cos1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px2_q     <= side1_q.range_q18 * sin_abs[14:0];
      py2_q     <= side1_q.range_q18 * cos_abs[14:0];
      sx_neg2_q <= sin1_q[15];
      sy_neg2_q <= cos1_q[15];
      keep2_q   <= side1_q.keep;
      inten2_q  <= side1_q.intensity;
    end
  end

  // Stage 3: truncate toward zero, add to the center, saturate
  logic signed [14:0] off_x;
  logic signed [14:0] off_y;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               v3_q;
  point_out_t         out_q;

  assign off_x = sx_neg2_q ? -$signed({1'b0, px2_q[46:33]}) : $signed({1'b0, px2_q[46:33]});
  assign off_y = sy_neg2_q ? -$signed({1'b0, py2_q[46:33]}) : $signed({1'b0, py2_q[46:33]});
  assign pos_x = $signed({5'b0, center_x_i}) + {off_x[14], off_x};
  assign pos_y = $signed({5'b0, center_y_i}) - {off_y[14], off_y};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.keep      <= keep2_q;
      out_q.screen_x  <= keep2_q ? sat12(pos_x) : 12'sd0;
      out_q.screen_y  <= keep2_q ? sat12(pos_y) : 12'sd0;
      out_q.intensity <= inten2_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_point_filter_and_projection_core.sv -----
// Range-finder point filter and polar-to-screen projection, top level.
// Pipeline: CORDIC_STAGES + 4 register stages between input transfer and output valid.
// Throughput: one point per cycle; a stalled output freezes the whole pipeline.
// Reset clears all valid bits and loads the register reset values.
// Instantiates lpfp_front, lpfp_cordic and lpfp_project; depends on lpfp_pkg.
`default_nettype none

module lidar_point_filter_and_projection_core import lpfp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned QUALITY_SHIFT = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire point_in_t           in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output point_out_t               out_data_o
);

  // Configuration registers
  logic [5:0]  min_quality_q;
  logic [13:0] max_distance_q;
  logic [15:0] scale_q;
  logic [10:0] center_x_q;
  logic [10:0] center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_quality_q  <= 6'd10;
      max_distance_q <= 14'd12000;
      scale_q        <= 16'd1911;
      center_x_q     <= 11'd400;
      center_y_q     <= 11'd400;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MIN_QUALITY:  min_quality_q  <= cfg_wdata_i[5:0];
        CFG_MAX_DISTANCE: max_distance_q <= cfg_wdata_i[13:0];
        CFG_SCALE:        scale_q        <= cfg_wdata_i;
        CFG_CENTER_X:     center_x_q     <= cfg_wdata_i[10:0];
        CFG_CENTER_Y:     center_y_q     <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a result waits on a stall
  logic pipe_en;
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  logic               fr_valid;
  logic signed [31:0] fr_z;
  side_t              fr_side;
  logic               cd_valid;
  logic signed [31:0] cd_cos;
  logic signed [31:0] cd_sin;
  side_t              cd_side;

  lpfp_front #(
    .QUALITY_SHIFT (QUALITY_SHIFT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (pipe_en),
    .valid_i        (in_valid_i),
    .data_i         (in_data_i),
    .min_quality_i  (min_quality_q),
    .max_distance_i (max_distance_q),
    .scale_i        (scale_q),
    .valid_o        (fr_valid),
    .z_o            (fr_z),
    .side_o         (fr_side)
  );

  lpfp_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fr_valid),
    .z_i     (fr_z),
    .side_i  (fr_side),
    .valid_o (cd_valid),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin),
    .side_o  (cd_side)
  );

  lpfp_project u_project (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (cd_valid),
    .cos_i      (cd_cos),
    .sin_i      (cd_sin),
    .side_i     (cd_side),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o)
  );

  // Checks
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.keep |->
      out_data_o.screen_x == 12'sd0 && out_data_o.screen_y == 12'sd0)
    else $error("dropped point carries coordinates");

  a_inten_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.intensity[7])
    else $error("intensity below 128");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Regression for the range-finder point filter and projection core.
// Predicts every result from its own fixed-point model and checks it in order.
// Depends on lpfp_pkg and lidar_point_filter_and_projection_core.
`timescale 1ns / 100ps

module testbench;
  import lpfp_pkg::*;

  localparam int unsigned Stages      = 16;
  localparam int unsigned QualShift   = 2;
  localparam int unsigned Latency     = Stages + 4;
  localparam int unsigned HoldCycles  = 300;

  // Rotation angles, units of 2^32 per turn
  localparam longint RotAngle [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  point_in_t           in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  point_out_t          out_data_o;

  // Register shadow
  int unsigned min_qual_r;
  int unsigned max_dist_r;
  int unsigned scale_r;
  int unsigned center_x_r;
  int unsigned center_y_r;

  point_out_t  expected_pts [$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;
  int unsigned hold_cnt      = 0;
  int unsigned n_fail        = 0;
  int unsigned n_sent        = 0;
  int unsigned n_checked     = 0;
  int unsigned n_kept        = 0;

  lidar_point_filter_and_projection_core #(
    .CORDIC_STAGES(Stages),
    .QUALITY_SHIFT(QualShift)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Q1.15 rounding with symmetric clamp
  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  // trunc(range * t / 2^33)
  function automatic longint pixel_offset(longint unsigned range, longint t);
    longint unsigned mag;
    longint          v;
    mag = (t < 0) ? longint'(-t) : longint'(t);
    v = longint'((range * mag) >> 33);
    return (t < 0) ? -v : v;
  endfunction

  function automatic logic [11:0] clamp_screen(longint v);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[11:0];
  endfunction

  // Expected result for one measurement under the current registers
  function automatic point_out_t project_point(point_in_t p);
    point_out_t      res;
    int unsigned     q;
    int unsigned     inten;
    int unsigned     dist_q2;
    longint          a, x, y, z, dx, dy, s, c;
    longint unsigned range;
    logic            flip;
    res     = '0;
    dist_q2 = 32'(p.distance_q2);
    q       = 32'(p.quality_raw >> QualShift);
    inten   = 128 + (q * 127) / 255;
    if (inten > 255) inten = 255;
    res.intensity = inten[7:0];
    res.keep = (dist_q2 != 0) && (q >= min_qual_r) && (dist_q2 <= 4 * max_dist_r);
    if (res.keep) begin
      // fold bearing into the right half plane
      a = longint'(p.angle_phase);
      flip = 1'b0;
      if (a >= 32768) a -= 65536;
      if (a > 16384) begin
        a -= 32768;
        flip = 1'b1;
      end else if (a < -16384) begin
        a += 32768;
        flip = 1'b1;
      end
      z = a * 65536;
      x = 652032874;
      y = 0;
      for (int i = 0; i < Stages && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= RotAngle[i];
        end else begin
          x += dx;
          y -= dy;
          z += RotAngle[i];
        end
      end
      c = round_q15(x);
      s = round_q15(y);
      if (flip) begin
        c = -c;
        s = -s;
      end
      range = longint'(dist_q2) * longint'(scale_r);
      res.screen_x = clamp_screen(longint'(center_x_r) + pixel_offset(range, s));
      res.screen_y = clamp_screen(longint'(center_y_r) - pixel_offset(range, c));
    end
    return res;
  endfunction

  function automatic point_in_t mk_point(int d, int a, int q);
    point_in_t p;
    p.distance_q2 = d[15:0];
    p.angle_phase = a[15:0];
    p.quality_raw = q[7:0];
    return p;
  endfunction

  // Mostly well-formed points near the current filter window, some noise
  function automatic point_in_t random_point();
    point_in_t   p;
    int unsigned sel;
    int unsigned lim;
    int unsigned qmin;
    sel  = $urandom_range(99);
    lim  = 4 * max_dist_r;
    if (lim < 1) lim = 1;
    if (lim > 65535) lim = 65535;
    qmin = 4 * min_qual_r;
    if (qmin > 255) qmin = 255;
    p.distance_q2 = 16'($urandom);
    p.angle_phase = 16'($urandom);
    p.quality_raw = 8'($urandom);
    if (sel < 70) begin
      p.distance_q2 = 16'($urandom_range(lim, 1));
      p.quality_raw = 8'($urandom_range(255, qmin));
    end else if (sel < 80) begin
      p.distance_q2 = ($urandom_range(1) == 0) ? 16'(lim) : 16'(lim + 1);
      p.quality_raw = ($urandom_range(1) == 0) ? 8'(qmin) : 8'(qmin - 1);
    end
    // quadrant boundaries
    if ($urandom_range(9) == 0) begin
      p.angle_phase = 16'(16384 * $urandom_range(3)) + 16'($urandom_range(2)) - 16'd1;
    end
    return p;
  endfunction

  // Offer one point and wait for its transfer
  task automatic send_point(input point_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_pts.push_back(project_point(p));
    n_sent++;
  endtask

  // Let the pipeline empty out
  task automatic drain_idle();
    in_valid_i <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN_QUALITY:  min_qual_r = val & 32'h3F;
      CFG_MAX_DISTANCE: max_dist_r = val & 32'h3FFF;
      CFG_SCALE:        scale_r    = val & 32'hFFFF;
      CFG_CENTER_X:     center_x_r = val & 32'h7FF;
      CFG_CENTER_Y:     center_y_r = val & 32'h7FF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_config(int unsigned mq, int unsigned md, int unsigned sc,
                              int unsigned cx, int unsigned cy);
    drain_idle();
    cfg_write(CFG_MIN_QUALITY, mq);
    cfg_write(CFG_MAX_DISTANCE, md);
    cfg_write(CFG_SCALE, sc);
    cfg_write(CFG_CENTER_X, cx);
    cfg_write(CFG_CENTER_Y, cy);
  endtask

  task automatic set_idling(int unsigned src_pct, int unsigned dst_pct);
    send_idle_pct = src_pct;
    stall_pct     = dst_pct;
  endtask

  // Directed points against the reset register values
  task automatic test_reset_values();
    set_idling(0, 0);
    send_point(mk_point(0, 0, 255));          // no reading
    send_point(mk_point(1, 0, 255));          // shortest distance
    send_point(mk_point(48000, 16384, 40));   // at distance limit, at quality limit
    send_point(mk_point(48001, 16384, 255));  // just past distance limit
    send_point(mk_point(2000, 0, 39));        // just under quality limit
    send_point(mk_point(65535, 0, 255));      // largest distance
    send_point(mk_point(4000, 0, 0));         // lowest quality byte
    send_point(mk_point(4000, 16384, 255));
    send_point(mk_point(4000, 16385, 255));   // just past right angle, folded
    send_point(mk_point(4000, 32767, 255));
    send_point(mk_point(4000, 32768, 255));   // half turn
    send_point(mk_point(4000, 49151, 255));
    send_point(mk_point(4000, 49152, 255));
    send_point(mk_point(4000, 49153, 255));
    send_point(mk_point(4000, 65535, 255));
    send_point(mk_point(48000, 8192, 128));
    send_point(mk_point(48000, 40960, 200));
    send_point(mk_point(12345, 16'hAAAA, 8'h55));
    send_point(mk_point(54321, 16'h5555, 8'hAA));
    drain_idle();
  endtask

  // Register extremes, each with a batch of random points
  task automatic test_register_extremes();
    set_idling(20, 20);
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: apply_config(0, 16383, 65535, 2047, 2047);  // saturates high and low
        1: apply_config(63, 16383, 0, 0, 2047);
        2: apply_config(0, 0, 30000, 1024, 1024);      // drops every point
        default: apply_config(0, 16383, 65535, 0, 0);
      endcase
      send_point(mk_point(65535, 16384, 0));
      send_point(mk_point(65535, 49152, 255));
      for (int i = 0; i < 22; i++) send_point(random_point());
    end
  endtask

  // Random registers under each idling pattern
  task automatic test_random_traffic();
    int unsigned sc;
    for (int ph = 0; ph < 4; ph++) begin
      sc = ($urandom_range(9) < 3) ? $urandom_range(65535) : $urandom_range(4000, 200);
      apply_config($urandom_range(20), $urandom_range(16383), sc,
                   $urandom_range(2047), $urandom_range(2047));
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(58, 0);
        2: set_idling(0, 58);
        default: set_idling(20, 20);
      endcase
      for (int i = 0; i < 170; i++) send_point(random_point());
    end
  endtask

  // Long output hold while the source keeps pushing
  task automatic test_output_hold();
    apply_config(10, 12000, 1911, 400, 400);
    set_idling(0, 0);
    hold_req <= 1'b1;
    for (int i = 0; i < 60; i++) send_point(random_point());
    drain_idle();
  endtask

  // Output stall generator, with an occasional long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req    <= 1'b0;
        hold_cnt    = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : chk
    point_out_t exp_pt;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pts.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result %h", $time, out_data_o);
      end else begin
        exp_pt = expected_pts.pop_front();
        n_checked++;
        if (exp_pt.keep) n_kept++;
        if (out_data_o.keep !== exp_pt.keep) begin
          n_fail++;
          $display("%0t: keep expected %0d got %0d", $time, exp_pt.keep, out_data_o.keep);
        end
        if (out_data_o.screen_x !== exp_pt.screen_x) begin
          n_fail++;
          $display("%0t: screen_x expected %0d got %0d", $time,
                   exp_pt.screen_x, out_data_o.screen_x);
        end
        if (out_data_o.screen_y !== exp_pt.screen_y) begin
          n_fail++;
          $display("%0t: screen_y expected %0d got %0d", $time,
                   exp_pt.screen_y, out_data_o.screen_y);
        end
        if (out_data_o.intensity !== exp_pt.intensity) begin
          n_fail++;
          $display("%0t: intensity expected %0d got %0d", $time,
                   exp_pt.intensity, out_data_o.intensity);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("lidar_point_filter_and_projection_core regression: fail");
    $finish;
  end

  initial begin
    min_qual_r = 10;
    max_dist_r = 12000;
    scale_r    = 1911;
    center_x_r = 400;
    center_y_r = 400;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_values();
    test_register_extremes();
    test_random_traffic();
    test_output_hold();

    drain_idle();
    $display("Checked %0d of %0d points (%0d kept) over reset, extreme and random registers,",
             n_checked, n_sent, n_kept);
    $display("with source gaps, sink stalls and a long output hold; %0d mismatches.", n_fail);
    if (n_fail == 0 && expected_pts.size() == 0) begin
      $display("lidar_point_filter_and_projection_core regression: pass");
    end else begin
      $display("lidar_point_filter_and_projection_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lpfp_pkg.sv
hw/rtl/lpfp_front.sv
hw/rtl/lpfp_cordic.sv
hw/rtl/lpfp_project.sv
hw/rtl/lidar_point_filter_and_projection_core.sv
tb/testbench.sv
